// ----- hdl/frf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frf_pkg
// shared sizes, operation codes and status codes of the filtered request fifo
// ----------------------------------------------------------------------------
package frf_pkg;

  // queue storage
  localparam int DEPTH        = 1024;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int PAYLOAD_BITS = 32;

  // blocklist
  localparam int DENY_ENTRIES = 8;
  localparam int DENY_IDX_W   = (DENY_ENTRIES > 1) ? $clog2(DENY_ENTRIES) : 1;

  // field widths
  localparam int FUNC_W   = 3;
  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 32;
  localparam int LIMIT_W  = 11;

  localparam logic [LIMIT_W-1:0] MAX_SIZE_RESET = LIMIT_W'(1000);

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ENQ     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEQ     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_BLOCK   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UNBLOCK = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DENY_FULL = 3'd4;

endpackage : frf_pkg
`default_nettype wire

// ----- hdl/filtered_request_fifo_unit.sv -----
`default_nettype none
// an accepted transaction moves the unit to S_RES; from S_RES the result is loaded into
//   the output register once that register is free; no new transaction is taken until then,
//   and S_RES covers the registered read of the slot memory that a dequeue waits for
// one input transaction is taken while the previous result still waits on out_tready
// reset (synchronous, rst_n low): queue empty, pointers and totals zero, blocklist
//   empty, limit 1000; the slot memory is not cleared, so no sweep follows reset
// ----------------------------------------------------------------------------
// filtered_request_fifo_unit
// bounded request queue with an address blocklist on admission
// ----------------------------------------------------------------------------
module filtered_request_fifo_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration: occupancy limit
  input  wire logic         cfg_we,
  input  wire logic [10:0]  cfg_wdata,    // max_size
  // input transaction
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,     // client_addr[31:0], request_data[63:32]
  input  wire logic [2:0]   in_tuser,     // func[2:0]
  // result transaction
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [143:0]      out_tdata,    // status[2:0], out_addr[34:3], out_data[66:35],
                                          // occupancy[77:67], added_total[109:78],
                                          // removed_total[141:110], zero[143:142]
  output logic [0:0]        out_tuser     // out_valid[0]
);
  import frf_pkg::*;

  typedef enum logic [0:0] {S_IDLE, S_RES} state_t;

  // ---------------------------------------------------------------- state
  state_t                    state_r;
  logic [PTR_W-1:0]          head_r, tail_r;
  logic [CNT_W-1:0]          fill_r;
  logic [TOTAL_W-1:0]        added_r, removed_r;
  logic [LIMIT_W-1:0]        max_size_r;
  logic [ADDR_W-1:0]         deny_addr_r [DENY_ENTRIES];
  logic [DENY_ENTRIES-1:0]   deny_used_r;

  // slot memory, one write or one read per cycle
  logic [ADDR_W-1:0]         mem_addr [DEPTH];
  logic [PAYLOAD_BITS-1:0]   mem_data [DEPTH];
  logic [ADDR_W-1:0]         rd_addr_r;
  logic [PAYLOAD_BITS-1:0]   rd_data_r;

  // pending result, waiting for the output register
  logic [STATUS_W-1:0]       res_status_r;
  logic                      res_deq_r;

  // output register
  logic                      out_tvalid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic                      out_flag_r;
  logic [ADDR_W-1:0]         out_addr_r;
  logic [DATA_W-1:0]         out_data_r;
  logic [CNT_W-1:0]          out_occ_r;
  logic [TOTAL_W-1:0]        out_added_r, out_removed_r;

  // ---------------------------------------------------------------- decode
  logic [FUNC_W-1:0]         in_func;
  logic [ADDR_W-1:0]         in_addr;
  logic [PAYLOAD_BITS-1:0]   in_payload;
  logic                      in_acc;
  logic                      out_load;

  assign in_func    = in_tuser;
  assign in_addr    = in_tdata[ADDR_W-1:0];
  assign in_payload = PAYLOAD_BITS'(in_tdata[ADDR_W +: DATA_W]);
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_RES) && (!out_tvalid_r || out_tready);

  // blocklist lookup: match and first free entry, all entries in parallel
  logic [DENY_ENTRIES-1:0]   deny_match;
  logic                      deny_hit;
  logic [DENY_IDX_W-1:0]     hit_idx;
  logic                      free_any;
  logic [DENY_IDX_W-1:0]     free_idx;

  always_comb begin
    deny_match = '0;
    hit_idx    = '0;
    free_any   = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < DENY_ENTRIES; i++) begin
      deny_match[i] = deny_used_r[i] && (deny_addr_r[i] == in_addr);
    end
    for (int i = DENY_ENTRIES - 1; i >= 0; i--) begin
      if (deny_match[i]) begin
        hit_idx = DENY_IDX_W'(i);
      end
      if (!deny_used_r[i]) begin
        free_any = 1'b1;
        free_idx = DENY_IDX_W'(i);
      end
    end
  end
  assign deny_hit = |deny_match;

  // operation decision
  logic                      q_full, q_empty;
  logic                      enq_do, deq_do, blk_do, unblk_do, clr_do;
  logic [STATUS_W-1:0]       status_nxt;

  assign q_full  = (fill_r >= CNT_W'(max_size_r)) || (fill_r >= CNT_W'(DEPTH));
  assign q_empty = (fill_r == '0);

  always_comb begin
    enq_do     = 1'b0;
    deq_do     = 1'b0;
    blk_do     = 1'b0;
    unblk_do   = 1'b0;
    clr_do     = 1'b0;
    status_nxt = ST_OK;
    case (in_func)
      FN_ENQ: begin
        if (deny_hit) begin
          status_nxt = ST_BLOCKED;
        end else if (q_full) begin
          status_nxt = ST_FULL;
        end else begin
          enq_do = 1'b1;
        end
      end
      FN_DEQ: begin
        if (q_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          deq_do = 1'b1;
        end
      end
      FN_BLOCK: begin
        // an address already listed is a no-op
        if (!deny_hit) begin
          if (free_any) begin
            blk_do = 1'b1;
          end else begin
            status_nxt = ST_DENY_FULL;
          end
        end
      end
      FN_UNBLOCK: begin
        unblk_do = deny_hit;
      end
      FN_CLEAR: begin
        clr_do = 1'b1;
      end
      default: begin
        // undefined codes do nothing and report current counts
      end
    endcase
  end

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- slot memory
  always_ff @(posedge clk) begin
    if (in_acc && enq_do) begin
      mem_addr[tail_r] <= in_addr;
      mem_data[tail_r] <= in_payload;
    end
    if (in_acc && deq_do) begin
      rd_addr_r <= mem_addr[head_r];
      rd_data_r <= mem_data[head_r];
    end
  end

  // blocklist addresses, no reset: only used entries are compared
  always_ff @(posedge clk) begin
    if (in_acc && blk_do) begin
      deny_addr_r[free_idx] <= in_addr;
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
      added_r      <= '0;
      removed_r    <= '0;
      max_size_r   <= MAX_SIZE_RESET;
      deny_used_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_size_r <= cfg_wdata;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_status_r <= status_nxt;
            res_deq_r    <= deq_do;
            if (enq_do) begin
              tail_r  <= ptr_inc(tail_r);
              fill_r  <= fill_r + CNT_W'(1);
              added_r <= added_r + TOTAL_W'(1);
            end
            if (deq_do) begin
              head_r    <= ptr_inc(head_r);
              fill_r    <= fill_r - CNT_W'(1);
              removed_r <= removed_r + TOTAL_W'(1);
            end
            if (clr_do) begin
              head_r <= '0;
              tail_r <= '0;
              fill_r <= '0;
            end
            if (blk_do) begin
              deny_used_r[free_idx] <= 1'b1;
            end
            if (unblk_do) begin
              deny_used_r[hit_idx] <= 1'b0;
            end
            state_r <= S_RES;
          end
        end
        S_RES: begin
          // counts are stable here, the next transaction is not yet taken
          if (out_load) begin
            out_status_r  <= res_status_r;
            out_flag_r    <= res_deq_r;
            out_addr_r    <= res_deq_r ? rd_addr_r : '0;
            out_data_r    <= res_deq_r ? DATA_W'(rd_data_r) : '0;
            out_occ_r     <= fill_r;
            out_added_r   <= added_r;
            out_removed_r <= removed_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- outputs
  assign out_tvalid   = out_tvalid_r;
  assign out_tuser[0] = out_flag_r;
  assign out_tdata    = {2'b00, out_removed_r, out_added_r, out_occ_r,
                         out_data_r, out_addr_r, out_status_r};

  // ---------------------------------------------------------------- checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_acc_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_RES))
    else $error("accepted transaction did not enter result stage");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && enq_do) |=> (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("enqueue did not grow the queue");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_flag_r) |-> (out_status_r == ST_OK))
    else $error("dequeued request reported with error status");

endmodule : filtered_request_fifo_unit
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the filtered request fifo: an in-bench model of the
// queue and blocklist predicts every result, which is checked field by field
// ----------------------------------------------------------------------------
module tb;
  import frf_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                valid;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
    logic [CNT_W-1:0]    occupancy;
    logic [TOTAL_W-1:0]  added;
    logic [TOTAL_W-1:0]  removed;
  } frf_result_t;

  class frf_tracker;
    // model of the queue
    logic [ADDR_W-1:0]  q_addr [DEPTH];
    logic [DATA_W-1:0]  q_data [DEPTH];
    logic [PTR_W-1:0]   head;
    logic [PTR_W-1:0]   tail;
    logic [CNT_W-1:0]   fill;
    logic [TOTAL_W-1:0] added;
    logic [TOTAL_W-1:0] removed;
    logic [LIMIT_W-1:0] limit;
    // model of the blocklist
    logic [ADDR_W-1:0]  deny_addr [DENY_ENTRIES];
    bit                 deny_used [DENY_ENTRIES];

    frf_result_t expected_q[$];

    int errors, checked;
    int n_enq, n_blocked, n_full, n_deq, n_empty, n_deny_full, n_clear, n_undef;
    int peak;

    function new();
      head    = '0;
      tail    = '0;
      fill    = '0;
      added   = '0;
      removed = '0;
      limit   = MAX_SIZE_RESET;
      foreach (deny_used[i]) deny_used[i] = 1'b0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int deny_index(logic [ADDR_W-1:0] a);
      for (int i = 0; i < DENY_ENTRIES; i++)
        if (deny_used[i] && deny_addr[i] == a) return i;
      return -1;
    endfunction

    // one accepted request -> one expected result
    function void note_request(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] a,
                               logic [DATA_W-1:0] d);
      frf_result_t r;
      int hit;
      int free_idx;
      r.status = ST_OK;
      r.valid  = 1'b0;
      r.addr   = '0;
      r.data   = '0;
      hit      = deny_index(a);
      free_idx = -1;
      case (fn)
        FN_ENQ: begin
          if (hit >= 0) begin
            r.status = ST_BLOCKED;
            n_blocked++;
          end else if (fill >= limit || fill >= DEPTH) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            q_addr[tail] = a;
            q_data[tail] = d;
            tail = (tail == DEPTH - 1) ? '0 : tail + 1'b1;
            fill++;
            added++;
            n_enq++;
            if (fill > peak) peak = fill;
          end
        end
        FN_DEQ: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            r.valid = 1'b1;
            r.addr  = q_addr[head];
            r.data  = q_data[head];
            head = (head == DEPTH - 1) ? '0 : head + 1'b1;
            fill--;
            removed++;
            n_deq++;
          end
        end
        FN_BLOCK: begin
          if (hit < 0) begin
            for (int i = 0; i < DENY_ENTRIES; i++)
              if (!deny_used[i] && free_idx < 0) free_idx = i;
            if (free_idx >= 0) begin
              deny_used[free_idx] = 1'b1;
              deny_addr[free_idx] = a;
            end else begin
              r.status = ST_DENY_FULL;
              n_deny_full++;
            end
          end
        end
        FN_UNBLOCK: begin
          if (hit >= 0) deny_used[hit] = 1'b0;
        end
        FN_CLEAR: begin
          fill = '0;
          head = '0;
          tail = '0;
          n_clear++;
        end
        default: begin
          n_undef++;
        end
      endcase
      r.occupancy = fill;
      r.added     = added;
      r.removed   = removed;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_response(logic [143:0] td, logic [0:0] tu);
      frf_result_t got;
      frf_result_t want;
      got.status    = td[2:0];
      got.addr      = td[34:3];
      got.data      = td[66:35];
      got.occupancy = td[77:67];
      got.added     = td[109:78];
      got.removed   = td[141:110];
      got.valid     = tu[0];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing pending: %h", td);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status || got.valid !== want.valid ||
          got.addr !== want.addr || got.data !== want.data ||
          got.occupancy !== want.occupancy || got.added !== want.added ||
          got.removed !== want.removed) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at result %0d: exp st=%0d v=%0d a=%h d=%h occ=%0d add=%0d rem=%0d",
                   checked, want.status, want.valid, want.addr, want.data,
                   want.occupancy, want.added, want.removed);
          $display("                        got st=%0d v=%0d a=%h d=%h occ=%0d add=%0d rem=%0d",
                   got.status, got.valid, got.addr, got.data,
                   got.occupancy, got.added, got.removed);
        end
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 300000;
  localparam int POOL_SIZE   = 13;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [63:0]        in_tdata   = '0;   // client_addr[31:0], request_data[63:32]
  logic [2:0]         in_tuser   = '0;   // func[2:0]
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [143:0]       out_tdata;         // status, out_addr, out_data, occupancy, totals
  logic [0:0]         out_tuser;         // out_valid[0]

  frf_tracker trk;

  // idling control: sender gaps and receiver stalls
  bit idle_on  = 1'b0;
  bit stall_on = 1'b0;
  int stall_cnt = 0;
  int limit_writes = 0;

  // small address pool so that blocklist hits and a full table happen often
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  filtered_request_fifo_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls on out_tready while stall_on is set
  always @(posedge clk) begin
    if (stall_cnt > 0) stall_cnt--;
    else if (stall_on && $urandom_range(0, 4) == 0) stall_cnt = $urandom_range(1, 3);
    out_tready <= (stall_cnt == 0);
  end

  // result monitor: every accepted result transaction is checked
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) trk.check_response(out_tdata, out_tuser);
  end

  // drive one request and hold it until accepted, then maybe leave a gap
  task automatic send_item(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] a,
                           logic [DATA_W-1:0] d);
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {d, a};
    do @(posedge clk); while (!in_tready);
    trk.note_request(fn, a, d);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // stop sending and let every pending result come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // limit register write, only while nothing is in flight
  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    trk.set_limit(v);
    limit_writes++;
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 3) != 0) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // random operations; enq_pct sets how hard the queue is pushed toward full
  task automatic run_random(int count, int enq_pct, bit calm);
    int r;
    logic [FUNC_W-1:0] fn;
    for (int k = 0; k < count; k++) begin
      // alternate stretches with and without idling
      if (!calm && k % 64 == 0) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < enq_pct)  fn = FN_ENQ;
      else if (r < 80)  fn = FN_DEQ;
      else if (r < 88)  fn = FN_BLOCK;
      else if (r < 96)  fn = FN_UNBLOCK;
      else if (r < 98)  fn = FN_CLEAR;
      else              fn = FUNC_W'($urandom_range(5, 7));   // undefined codes
      send_item(fn, pick_addr(), $urandom());
    end
  endtask

  task automatic run_phase(logic [LIMIT_W-1:0] lim, int count, int enq_pct, bit calm);
    wait_idle();
    write_limit(lim);
    run_random(count, enq_pct, calm);
  endtask

  initial begin
    addr_pool[0]  = 32'h0000_0000;
    addr_pool[1]  = 32'hFFFF_FFFF;
    for (int i = 0; i < DENY_ENTRIES; i++) addr_pool[2 + i] = 32'h0A00_0000 + i;
    addr_pool[10] = 32'h0B00_0000;
    addr_pool[11] = $urandom();
    addr_pool[12] = $urandom();
    trk = new();

    // hold the synchronous reset low, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on  = 1'b1;
    stall_on = 1'b1;

    // directed part, limit still at its reset value
    send_item(FN_DEQ, 32'h0, 32'h0);                       // dequeue on empty queue
    send_item(FN_ENQ, 32'h0000_0000, 32'hFFFF_FFFF);       // field extremes
    send_item(FN_ENQ, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(FN_BLOCK, 32'hFFFF_FFFF, 32'h0);
    send_item(FN_BLOCK, 32'hFFFF_FFFF, 32'h0);             // already listed
    send_item(FN_ENQ, 32'hFFFF_FFFF, 32'h1234_5678);       // refused as blocked
    send_item(FN_UNBLOCK, 32'h0102_0304, 32'h0);           // absent address
    send_item(FN_UNBLOCK, 32'hFFFF_FFFF, 32'h0);
    send_item(FN_ENQ, 32'hFFFF_FFFF, 32'hA5A5_A5A5);       // admitted again
    for (int i = 0; i < DENY_ENTRIES; i++)
      send_item(FN_BLOCK, 32'h0A00_0000 + i, $urandom());  // fill the table
    send_item(FN_BLOCK, 32'h0B00_0000, 32'h0);             // blocklist full
    send_item(FN_ENQ, 32'h0A00_0003, 32'h5A5A_5A5A);
    send_item(3'd5, 32'h0, 32'h0);                         // undefined codes
    send_item(3'd6, 32'h0, 32'h0);
    send_item(3'd7, 32'h0, 32'h0);
    send_item(FN_DEQ, 32'h0, 32'h0);
    send_item(FN_DEQ, 32'h0, 32'h0);
    send_item(FN_CLEAR, 32'h0, 32'h0);
    send_item(FN_DEQ, 32'h0, 32'h0);                       // empty after clear

    // zero limit: blocked wins over full
    wait_idle();
    write_limit(11'd0);
    send_item(FN_ENQ, 32'h0A00_0005, 32'h1);
    send_item(FN_ENQ, 32'h1234_5678, 32'h2);

    // limit above depth: fill to depth, wrap the tail, read back a share
    wait_idle();
    write_limit(11'h7FF);
    send_item(FN_CLEAR, 32'h0, 32'h0);
    for (int i = 0; i < DEPTH + 1; i++) send_item(FN_ENQ, $urandom(), $urandom());
    for (int i = 0; i < 3; i++) begin
      send_item(FN_DEQ, 32'h0, 32'h0);
      send_item(FN_ENQ, $urandom(), $urandom());
    end
    for (int i = 0; i < 4; i++) send_item(FN_DEQ, 32'h0, 32'h0);
    send_item(FN_CLEAR, 32'h0, 32'h0);

    // random phases over a spread of limits
    run_phase(11'd3,    20, 60, 1'b0);
    run_phase(11'd0,    10, 45, 1'b0);
    run_phase(11'd1,    15, 45, 1'b0);
    run_phase(11'h7FF,  10, 55, 1'b0);
    // closing stretch with no idling on either side
    idle_on  = 1'b0;
    stall_on = 1'b0;
    run_phase(11'd16,   25, 60, 1'b1);

    wait_idle();
    repeat (10) @(posedge clk);

    $display("covered %0d results over %0d limit writes: %0d admitted, %0d blocked, %0d full",
             trk.checked, limit_writes, trk.n_enq, trk.n_blocked, trk.n_full);
    $display("%0d dequeued, %0d empty, %0d table full, %0d clears, %0d undefined, peak %0d",
             trk.n_deq, trk.n_empty, trk.n_deny_full, trk.n_clear, trk.n_undef, trk.peak);
    if (trk.errors == 0 && trk.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", trk.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/frf_pkg.sv
hdl/filtered_request_fifo_unit.sv
verif/tb.sv
